// ===== design/mpfb_pkg.sv =====
package mpfb_pkg;

  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned PageRows     = 8;
  localparam int unsigned PageCount    = (ScreenHeight + PageRows - 1) / PageRows;
  localparam int unsigned BufBytes     = ScreenWidth * PageCount;
  localparam int unsigned AddrW        = $clog2(BufBytes);
  localparam int unsigned XW           = $clog2(ScreenWidth + 1);
  localparam int unsigned YW           = $clog2(ScreenHeight + 1);
  localparam int unsigned PageW        = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int unsigned QDepth       = 2;

  typedef enum logic [2:0] {
    OP_PIXEL  = 3'd0,
    OP_FILL   = 3'd1,
    OP_INVERT = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SWAP   = 3'd4,
    OP_READ   = 3'd5,
    OP_NOP6   = 3'd6,
    OP_NOP7   = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RECT = 2'd1,
    KIND_SWAP = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  // Classified work item: clipped half-open rectangle, draw mode and read index.
  typedef struct packed {
    kind_e           kind;
    logic [1:0]      mode;   // 0 clear, 1 set, 2 invert
    logic [XW-1:0]   x0;
    logic [XW-1:0]   x1;
    logic [YW-1:0]   y0;
    logic [YW-1:0]   y1;
    logic [9:0]      ridx;
  } cmd_t;

  localparam logic [1:0] ModeClear  = 2'd0;
  localparam logic [1:0] ModeSet    = 2'd1;
  localparam logic [1:0] ModeInvert = 2'd2;

endpackage

// ===== design/mpfb_ram.sv =====
module mpfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/mpfb_front.sv =====
module mpfb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      opcode_i,
  input  logic [8:0]      pos_x_i,
  input  logic [8:0]      pos_y_i,
  input  logic [7:0]      rect_width_i,
  input  logic [7:0]      rect_height_i,
  input  logic            pen_color_i,
  input  logic [9:0]      read_index_i,
  output logic            q_valid_o,
  output mpfb_pkg::cmd_t  q_cmd_o,
  input  logic            q_pop_i
);
  import mpfb_pkg::*;

  cmd_t        cls;
  cmd_t        slot_q [QDepth];
  logic [1:0]  cnt_q, cnt_d;
  logic        wptr_q, rptr_q;
  logic        push;
  logic signed [10:0] sx, sy, ex, ey;
  logic [7:0]  w, h;

  // Classify command and clip the rectangle
  always_comb begin
    w = rect_width_i;
    h = rect_height_i;
    if (opcode_e'(opcode_i) == OP_PIXEL) begin
      w = 8'd1;
      h = 8'd1;
    end
    sx = {{2{pos_x_i[8]}}, pos_x_i};
    sy = {{2{pos_y_i[8]}}, pos_y_i};
    ex = sx + $signed({3'b0, w});
    ey = sy + $signed({3'b0, h});
    cls = '0;
    cls.ridx = read_index_i;
    cls.x0 = sx[10] ? '0 : (sx > 11'(ScreenWidth)  ? XW'(ScreenWidth)  : XW'(sx));
    cls.y0 = sy[10] ? '0 : (sy > 11'(ScreenHeight) ? YW'(ScreenHeight) : YW'(sy));
    cls.x1 = ex[10] ? '0 : (ex > 11'(ScreenWidth)  ? XW'(ScreenWidth)  : XW'(ex));
    cls.y1 = ey[10] ? '0 : (ey > 11'(ScreenHeight) ? YW'(ScreenHeight) : YW'(ey));
    unique case (opcode_e'(opcode_i))
      OP_PIXEL:  begin cls.kind = KIND_RECT; cls.mode = {1'b0, pen_color_i}; end
      OP_FILL:   begin cls.kind = KIND_RECT; cls.mode = {1'b0, pen_color_i}; end
      OP_INVERT: begin cls.kind = KIND_RECT; cls.mode = ModeInvert; end
      OP_CLEAR:  begin
        cls.kind = KIND_RECT; cls.mode = ModeClear;
        cls.x0 = '0; cls.y0 = '0;
        cls.x1 = XW'(ScreenWidth); cls.y1 = YW'(ScreenHeight);
      end
      OP_SWAP:   cls.kind = KIND_SWAP;
      OP_READ:   cls.kind = KIND_READ;
      default:   cls.kind = KIND_NONE;
    endcase
  end

  assign busy = (cnt_q == 2'(QDepth));
  assign push = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = slot_q[rptr_q];

  // Hold queued transactions
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= cls;
  end

  always_comb cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wptr_q <= 1'b0; rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
    end
  end
endmodule

// ===== design/mpfb_back.sv =====
module mpfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mpfb_pkg::cmd_t  q_cmd_i,
  output logic            q_pop_o,
  output logic            done_o,
  output logic [7:0]      read_byte_o,
  output logic            front_is_second_o
);
  import mpfb_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StFetch = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]       st_q, st_d;
  logic             front_q;
  cmd_t             cmd_q;
  logic [XW-1:0]    x_q;
  logic [PageW-1:0] pg_q;
  logic [AddrW-1:0] init_q;
  logic [7:0]       mask;
  logic [YW-1:0]    pg_lo, pg_hi;
  logic [AddrW-1:0] addr;
  logic             we0, we1;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata, rd0, rd1, rdb, nb;
  logic             last_x, last_pg, empty;
  logic             done_d;

  assign pg_lo = YW'({pg_q, 3'b000});
  assign pg_hi = pg_lo + YW'(8);
  assign addr  = AddrW'(AddrW'(pg_q) * AddrW'(ScreenWidth) + AddrW'(x_q));

  // Row mask for the current page
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = ((pg_lo + YW'(b)) >= cmd_q.y0) && ((pg_lo + YW'(b)) < cmd_q.y1)
                && ((pg_lo + YW'(b)) < YW'(ScreenHeight));
    end
  end

  assign rdb = front_q ? rd0 : rd1;   // back buffer data
  always_comb begin
    unique case (cmd_q.mode)
      ModeSet:    nb = rdb | mask;
      ModeInvert: nb = rdb ^ mask;
      default:    nb = rdb & ~mask;
    endcase
  end

  assign empty   = (cmd_q.x0 >= cmd_q.x1) || (cmd_q.y0 >= cmd_q.y1);
  assign last_x  = (x_q + XW'(1) >= cmd_q.x1);
  assign last_pg = (YW'(pg_hi) >= cmd_q.y1);

  // Write steering: the reset clear sweep hits both buffers
  always_comb begin
    we0 = 1'b0; we1 = 1'b0; waddr = addr; wdata = nb;
    if (st_q == StInit) begin
      we0 = 1'b1; we1 = 1'b1; waddr = init_q; wdata = '0;
    end else if (st_q == StWrite) begin
      we0 = front_q; we1 = !front_q;
    end
  end

  mpfb_ram #(.Width(8), .Depth(BufBytes)) u_ram0 (
    .clk_i, .we_i(we0), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(st_q == StFetch ? AddrW'(cmd_q.ridx) : addr), .rdata_o(rd0));
  mpfb_ram #(.Width(8), .Depth(BufBytes)) u_ram1 (
    .clk_i, .we_i(we1), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(st_q == StFetch ? AddrW'(cmd_q.ridx) : addr), .rdata_o(rd1));

  assign q_pop_o = (st_q == StIdle) && q_valid_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StInit:  if (init_q == AddrW'(BufBytes - 1)) st_d = StIdle;
      StIdle:  if (q_valid_i) begin
        priority case (q_cmd_i.kind)
          KIND_RECT: st_d = StRead;
          KIND_READ: st_d = StFetch;
          default:   st_d = StIdle;
        endcase
      end
      StRead:  st_d = empty ? StIdle : StWrite;
      StWrite: st_d = (last_x && last_pg) ? StIdle : StRead;
      StFetch: st_d = StOut;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Flag a result transaction for the next cycle
  always_comb begin
    done_d = (q_pop_o && (q_cmd_i.kind == KIND_SWAP || q_cmd_i.kind == KIND_NONE))
             || (st_q == StRead && empty)
             || (st_q == StWrite && last_x && last_pg)
             || (st_q == StOut);
  end

  // Sequence commands and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; front_q <= 1'b0; init_q <= '0; done_o <= 1'b0;
      read_byte_o <= '0; front_is_second_o <= 1'b0;
      cmd_q <= '0; x_q <= '0; pg_q <= '0;
    end else begin
      st_q <= st_d;
      done_o <= done_d;
      if (st_q == StInit) init_q <= init_q + AddrW'(1);
      if (q_pop_o) begin
        cmd_q <= q_cmd_i;
        x_q <= q_cmd_i.x0;
        pg_q <= PageW'(q_cmd_i.y0 >> 3);
        if (q_cmd_i.kind == KIND_SWAP || q_cmd_i.kind == KIND_NONE) begin
          read_byte_o <= '0;
          front_is_second_o <= front_q ^ (q_cmd_i.kind == KIND_SWAP);
          if (q_cmd_i.kind == KIND_SWAP) front_q <= ~front_q;
        end
      end
      if ((st_q == StRead && empty) || (st_q == StWrite && last_x && last_pg)) begin
        read_byte_o <= '0; front_is_second_o <= front_q;
      end
      if (st_q == StWrite && !(last_x && last_pg)) begin
        if (last_x) begin
          x_q <= cmd_q.x0; pg_q <= pg_q + PageW'(1);
        end else x_q <= x_q + XW'(1);
      end
      if (st_q == StOut) begin
        front_is_second_o <= front_q;
        read_byte_o <= ({1'b0, cmd_q.ridx} < 11'(BufBytes)) ? (front_q ? rd1 : rd0)
                                                            : 8'd0;
      end
    end
  end
endmodule

// ===== design/mono_page_framebuffer_draw.sv =====
// Monochrome page-mode framebuffer drawing engine, double buffered.
// Command channel: drive the fields with start high; the command is taken
// at a clock edge where busy is low. A two-entry queue parts command intake
// from execution, so up to two commands may wait.
// Result channel: done_o pulses for one cycle with read_byte_o and
// front_is_second_o; the receiver cannot stall, each command gives one result.
// Swap and unused opcodes give their result straight from the queue; a read
// of the front buffer passes the fetch and output states; pixel, fill,
// invert and clear visit each touched byte of the clipped rectangle, and
// an empty rectangle ends in the read state. The read-modify-write of one
// buffer byte through the registered RAM read sets the rectangle rate.
// After reset a sweep clears all BufBytes (1024) bytes of both buffers
// before queued commands start; commands can be queued meanwhile.
module mono_page_framebuffer_draw (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode_i,
  input  logic [8:0] pos_x_i,
  input  logic [8:0] pos_y_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic       pen_color_i,
  input  logic [9:0] read_index_i,
  output logic       done_o,
  output logic [7:0] read_byte_o,
  output logic       front_is_second_o
);
  import mpfb_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  mpfb_front u_front (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .pos_x_i, .pos_y_i,
    .rect_width_i, .rect_height_i, .pen_color_i, .read_index_i,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop));

  mpfb_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .done_o, .read_byte_o, .front_is_second_o);
endmodule

// ===== design/mpfb_checker.sv =====
module mpfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] read_byte_o,
  input logic       front_is_second_o
);

  // Keep handshake and result ports known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({busy, done_o, read_byte_o, front_is_second_o}))
    else $error("unknown value on outputs");

  // No result in the first cycle after reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o)
    else $error("result right after reset");

  // Front changes only with a result
  a_front_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(front_is_second_o))
    else $error("front changed");

  // Hold busy low in reset
  a_busy_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !busy)
    else $error("busy in reset");
endmodule

bind mono_page_framebuffer_draw mpfb_checker u_checker (.*);
